>>> rtl/etfi_pkg.sv
// Shared constants, types and fixed-point helpers for the escape-time fractal iterator.
// Depends on nothing; imported by rtl/escape_time_fractal_iterator.sv.

package etfi_pkg;

	// Coordinate format: signed, COORD_WIDTH bits, FRAC_BITS of them fractional
	localparam int COORD_WIDTH = 32;
	localparam int FRAC_BITS   = 26;
	localparam int PROD_WIDTH  = 2 * COORD_WIDTH;
	localparam int WIDE_WIDTH  = COORD_WIDTH + 1;

	localparam int TAG_WIDTH   = 12;
	localparam int COUNT_WIDTH = 12;

	localparam int IN_DATA_WIDTH  = 4 * COORD_WIDTH + 2 * TAG_WIDTH;
	localparam int IN_TDATA_WIDTH = ((IN_DATA_WIDTH + 7) / 8) * 8;
	localparam int OUT_DATA_WIDTH  = COUNT_WIDTH + 2 * TAG_WIDTH;
	localparam int OUT_TDATA_WIDTH = ((OUT_DATA_WIDTH + 7) / 8) * 8;

	localparam logic [COUNT_WIDTH-1:0] LIMIT_RESET = COUNT_WIDTH'(256);

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [PROD_WIDTH-1:0]  prod_t;
	typedef logic signed [WIDE_WIDTH-1:0]  wide_t;

	localparam prod_t PROD_COORD_MAX = PROD_WIDTH'(coord_t'({1'b0, {(COORD_WIDTH-1){1'b1}}}));
	localparam prod_t PROD_COORD_MIN = PROD_WIDTH'(coord_t'({1'b1, {(COORD_WIDTH-1){1'b0}}}));

	// Escape radius squared: 4.0 in the coordinate format, one bit wider
	localparam logic [WIDE_WIDTH-1:0] ESCAPE_BOUND =
		{{(COORD_WIDTH-FRAC_BITS-2){1'b0}}, 3'b100, {FRAC_BITS{1'b0}}};

	// Shift an exact product right toward zero, then clamp to the coordinate range
	function automatic coord_t fx_scale(input prod_t p, input int unsigned sh);
		logic [PROD_WIDTH-1:0] round_mask;
		prod_t                 biased;
		prod_t                 q;
		coord_t                r;
		round_mask = (PROD_WIDTH'(1) << sh) - PROD_WIDTH'(1);
		biased     = p[PROD_WIDTH-1] ? p + $signed(round_mask) : p;
		q          = biased >>> sh;
		if (q > PROD_COORD_MAX) begin
			r = coord_t'(PROD_COORD_MAX[COORD_WIDTH-1:0]);
		end else if (q < PROD_COORD_MIN) begin
			r = coord_t'(PROD_COORD_MIN[COORD_WIDTH-1:0]);
		end else begin
			r = coord_t'(q[COORD_WIDTH-1:0]);
		end
		return r;
	endfunction

	// Clamp a value one bit wider than a coordinate back to the coordinate range
	function automatic coord_t sat_wide(input wide_t v);
		coord_t r;
		if (v[WIDE_WIDTH-1] == v[WIDE_WIDTH-2]) begin
			r = coord_t'(v[COORD_WIDTH-1:0]);
		end else if (v[WIDE_WIDTH-1]) begin
			r = coord_t'({1'b1, {(COORD_WIDTH-1){1'b0}}});
		end else begin
			r = coord_t'({1'b0, {(COORD_WIDTH-1){1'b1}}});
		end
		return r;
	endfunction

endpackage

>>> rtl/escape_time_fractal_iterator.sv
// Escape-time fractal iterator: iterates z = z*z + c on one pixel item at a time.
// Depends on rtl/etfi_pkg.sv for the coordinate format and fixed-point helpers.
//
// Usage
//   Input stream (s_axis_*): one pixel item carries z0, c and the column/row tags.
//   Output stream (m_axis_*): one result item per pixel, the iteration count and tags.
//   Config channel (cfg_*): writes iteration_limit; always ready, write only when idle.
// Timing
//   One iteration runs on the shared datapath as a multiply step (three products of
//   the current z), a scale step (shift, round toward zero, clamp) and an update
//   step (escape and limit test, new z with c added and clamped). A pixel runs
//   until z escapes or its count reaches iteration_limit, 256 after reset.
//   s_axis_tready is high only while no pixel is being iterated.
// Reset
//   arst_n clears the sequencer and the output valid and sets iteration_limit to 256.
// Back-pressure
//   A finished result is parked in the output register. The input side reopens as
//   soon as a result is moved there; a further result waits in the sequencer until
//   the output register has been taken.

module escape_time_fractal_iterator (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// start_real, start_imag, const_real, const_imag, pixel_column, pixel_row
	input  logic [etfi_pkg::IN_TDATA_WIDTH-1:0]  s_axis_tdata,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// iteration_count, out_column, out_row, zero fill
	output logic [etfi_pkg::OUT_TDATA_WIDTH-1:0] m_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	input  logic [etfi_pkg::COUNT_WIDTH-1:0]     cfg_data,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready
);
	import etfi_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_MUL   = 3'd1;
	localparam logic [2:0] ST_SCALE = 3'd2;
	localparam logic [2:0] ST_STEP  = 3'd3;
	localparam logic [2:0] ST_HOLD  = 3'd4;

	logic [2:0]             state_q;
	logic [COUNT_WIDTH-1:0] limit_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic [TAG_WIDTH-1:0]   column_q;
	logic [TAG_WIDTH-1:0]   row_q;
	coord_t                 zr_q;
	coord_t                 zi_q;
	coord_t                 cr_q;
	coord_t                 ci_q;
	prod_t                  prod_rr_q;
	prod_t                  prod_ii_q;
	prod_t                  prod_ri_q;
	coord_t                 sq_r_q;
	coord_t                 sq_i_q;
	coord_t                 cross_q;
	logic                   out_valid_q;
	logic [OUT_DATA_WIDTH-1:0] out_data_q;

	wide_t                  diff_w;
	coord_t                 diff_sat;
	coord_t                 next_zr;
	coord_t                 next_zi;
	logic [WIDE_WIDTH-1:0]  mag_sum;
	logic                   finished;
	logic                   out_free;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_TDATA_WIDTH'(out_data_q);
	assign out_free      = !out_valid_q || m_axis_tready;

	// Update step: new z from the clamped products, escape test on the current squares
	always_comb begin
		diff_w   = WIDE_WIDTH'(sq_r_q) - WIDE_WIDTH'(sq_i_q);
		diff_sat = sat_wide(diff_w);
		next_zr  = sat_wide(WIDE_WIDTH'(diff_sat) + WIDE_WIDTH'(cr_q));
		next_zi  = sat_wide(WIDE_WIDTH'(cross_q) + WIDE_WIDTH'(ci_q));
		mag_sum  = $unsigned(WIDE_WIDTH'(sq_r_q)) + $unsigned(WIDE_WIDTH'(sq_i_q));
		finished = (count_q >= limit_q)
			|| ((count_q != '0) && (mag_sum > ESCAPE_BOUND));
	end

	// Hold the iteration limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= cfg_data;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					state_q <= ST_STEP;
				end
				ST_STEP: begin
					state_q <= finished ? ST_HOLD : ST_MUL;
				end
				ST_HOLD: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output valid: raise when a result is parked, drop once it has been taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_HOLD) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Datapath: load the item, then multiply, scale and advance z in turn, and park the result
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					zr_q     <= coord_t'(s_axis_tdata[0*COORD_WIDTH +: COORD_WIDTH]);
					zi_q     <= coord_t'(s_axis_tdata[1*COORD_WIDTH +: COORD_WIDTH]);
					cr_q     <= coord_t'(s_axis_tdata[2*COORD_WIDTH +: COORD_WIDTH]);
					ci_q     <= coord_t'(s_axis_tdata[3*COORD_WIDTH +: COORD_WIDTH]);
					column_q <= s_axis_tdata[4*COORD_WIDTH +: TAG_WIDTH];
					row_q    <= s_axis_tdata[4*COORD_WIDTH+TAG_WIDTH +: TAG_WIDTH];
					count_q  <= '0;
				end
			end
			ST_MUL: begin
				prod_rr_q <= PROD_WIDTH'(zr_q) * PROD_WIDTH'(zr_q);
				prod_ii_q <= PROD_WIDTH'(zi_q) * PROD_WIDTH'(zi_q);
				prod_ri_q <= PROD_WIDTH'(zr_q) * PROD_WIDTH'(zi_q);
			end
			ST_SCALE: begin
				sq_r_q  <= fx_scale(prod_rr_q, FRAC_BITS);
				sq_i_q  <= fx_scale(prod_ii_q, FRAC_BITS);
				cross_q <= fx_scale(prod_ri_q, FRAC_BITS - 1);
			end
			ST_STEP: begin
				if (!finished) begin
					zr_q    <= next_zr;
					zi_q    <= next_zi;
					count_q <= count_q + COUNT_WIDTH'(1);
				end
			end
			ST_HOLD: begin
				if (out_free) begin
					out_data_q <= {row_q, column_q, count_q};
				end
			end
			default: begin
			end
		endcase
	end

endmodule
